[hdl/arp_cache_table_top_assert.svh]
// Assertion macros shared by the address cache modules.
`ifndef ARP_CACHE_TABLE_TOP_ASSERT_SVH
`define ARP_CACHE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ARPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/arpc_pkg.sv]
// Types and constants shared by the address cache modules.
package arpc_pkg;

  localparam int MAC_BYTES = 6;
  localparam int MAC_W     = MAC_BYTES * 8;
  localparam int IP_W      = 32;
  localparam int TIME_W    = 32;
  localparam int TMO_W     = 16;
  localparam int QDEPTH    = 2;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IP_W-1:0]  ip_address;
    logic [MAC_W-1:0] mac_address;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] found_mac;
    logic             stored;
  } rsp_t;

  typedef struct packed {
    logic             lookup;
    logic             insert;
    logic             tick;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] added;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[hdl/arp_cache_table_top.sv]
// Top level of the IPv4-to-MAC address cache with ageing.
// Each request beat is a lookup, an insert or a one-second tick. The table sits in
// one RAM with a single read port, and every command walks all entries through it
// once. Up to two requests queue ahead of the engine, and one result waits in the
// output register. After reset a clearing pass over all entries runs before the
// first request is served; requests are queued meanwhile and configuration writes
// are taken.
module arp_cache_table_top
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [TMO_W-1:0] cfg_wdata
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  arpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  arpc_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

[hdl/arpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/arpc_front.sv]
// Request intake: decodes each beat into a command and queues it for the table engine.
module arpc_front
  import arpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_pop,
  output cmd_t cmd
);

  `include "arp_cache_table_top_assert.svh"

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          q [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          push;
  cmd_t          decoded;

  assign req_stall = (count == CW'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign push      = req_valid && !req_stall;
  assign cmd       = q[rptr];

  always_comb begin
    decoded.lookup = (req.operation == OP_LOOKUP);
    decoded.insert = (req.operation == OP_INSERT);
    decoded.tick   = (req.operation == OP_TICK);
    decoded.ip     = req.ip_address;
    decoded.mac    = req.mac_address;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= decoded;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (cmd_pop) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(cmd_pop);
    end
  end

  `ARPC_ASSERT_IMPL(a_pop_nonempty, cmd_pop, cmd_valid, "command popped from empty queue")
  `ARPC_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(QDEPTH), "queue count over depth")

endmodule

[hdl/arpc_back.sv]
// Table engine: clears the table after reset, then scans it once per command.
module arpc_back
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  input  cmd_t             cmd,
  input  logic             cfg_we,
  input  logic [TMO_W-1:0] cfg_wdata,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp
);

  `include "arp_cache_table_top_assert.svh"

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state;
  logic [CW-1:0]     idx;
  logic              rvalid;
  logic [AW-1:0]     raddr;
  cmd_t              cur;
  logic [TIME_W-1:0] now;
  logic [TMO_W-1:0]  timeout;
  logic              free_found;
  logic [AW-1:0]     free_idx;
  logic              hit;
  logic [MAC_W-1:0]  mac;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_entry;
  logic              rd_en;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t            rd_entry;
  logic [TIME_W-1:0] age;
  logic              expired;
  logic              emit;
  logic              scan_more;

  assign rd_entry  = entry_t'(rd_raw);
  assign age       = now - rd_entry.added;
  assign expired   = rd_entry.valid && (age > {{(TIME_W - TMO_W){1'b0}}, timeout});
  assign scan_more = (idx < CW'(ENTRIES));
  assign rd_en     = (state == ST_SCAN) && scan_more;
  assign emit      = (state == ST_DONE) && (!rsp_valid || !rsp_stall);
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = idx[AW-1:0];
    wr_entry = '0;
    case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_SCAN: begin
        if (rvalid && cur.tick && expired) begin
          wr_en          = 1'b1;
          wr_addr        = raddr;
          wr_entry       = rd_entry;
          wr_entry.valid = 1'b0;
        end
      end
      ST_DONE: begin
        if (emit && cur.insert && free_found) begin
          wr_en          = 1'b1;
          wr_addr        = free_idx;
          wr_entry.valid = 1'b1;
          wr_entry.ip    = cur.ip;
          wr_entry.mac   = cur.mac;
          wr_entry.added = now;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  arpc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (rd_en) begin
      raddr <= idx[AW-1:0];
    end
    if (emit) begin
      rsp.hit       <= hit;
      rsp.found_mac <= mac;
      rsp.stored    <= cur.insert && free_found;
    end
    if (state == ST_IDLE) begin
      hit        <= 1'b0;
      mac        <= '0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN && rvalid) begin
      if (cur.lookup && rd_entry.valid && rd_entry.ip == cur.ip) begin
        hit <= 1'b1;
        mac <= rd_entry.mac;
      end
      if (cur.insert && !rd_entry.valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= raddr;
      end
    end
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      rvalid    <= 1'b0;
      now       <= '0;
      timeout   <= TMO_W'(15);
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (idx == CW'(ENTRIES - 1)) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            idx    <= '0;
            rvalid <= 1'b0;
            if (cmd.tick) begin
              now <= now + 1'b1;
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rvalid <= rd_en;
          if (rd_en) begin
            idx <= idx + 1'b1;
          end else if (!rvalid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ARPC_ASSERT_IMPL(a_scan_write, wr_en && state == ST_SCAN, rvalid && cur.tick,
                    "table write during scan without a tick read")
  `ARPC_ASSERT_NEXT(a_emit_valid, emit, rsp_valid, "result not presented after emit")
  `ARPC_ASSERT_IMPL(a_one_flag, rsp_valid, !(rsp.hit && rsp.stored),
                    "result flags both hit and stored")
  `ARPC_ASSERT_IMPL(a_no_pop_clear, state == ST_CLEAR, !cmd_pop,
                    "command taken during the clearing pass")

endmodule
